// ----- src/assert_macros.svh -----
// Concurrent assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KF2_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kf2 assertion failed");
`define KF2_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kf2 forbidden condition seen");
`else
`define KF2_ASSERT(lbl, prop)
`define KF2_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- src/kf2_pkg.sv -----
package kf2_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int FIELD_W   = 32;
  localparam int UNOISE_W  = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DIST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ANGLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST       = CFG_INIT_ANGLE;

  localparam logic [UNOISE_W-1:0] RST_INIT_COV   = 31'd65536;
  localparam logic [UNOISE_W-1:0] RST_PROC_NOISE = 31'd655;
  localparam logic [UNOISE_W-1:0] RST_MEAS_NOISE = 31'd6554;

  typedef struct packed {
    logic signed [FIELD_W-1:0] meas_distance;
    logic signed [FIELD_W-1:0] meas_angle;
    logic signed [FIELD_W-1:0] ctrl_distance;
    logic signed [FIELD_W-1:0] ctrl_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] filtered_distance;
    logic signed [FIELD_W-1:0] filtered_angle;
    logic                      gain_fault;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   value;
  } cfg_item_t;

  localparam int ADDR_W = 5;
  localparam int PC_W   = 7;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PC_W-1:0]   pc_t;

  typedef enum logic [3:0] {
    OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CHK, OP_JMP, OP_OUT, OP_END
  } op_e;

  typedef enum logic [3:0] {
    SRC_MEAS_D, SRC_MEAS_A, SRC_CTRL_D, SRC_CTRL_A, SRC_COV, SRC_Q, SRC_R,
    SRC_INIT_D, SRC_INIT_A, SRC_ZERO
  } src_e;

  // scratch file layout
  localparam addr_t A_XD   = 5'd0;
  localparam addr_t A_XA   = 5'd1;
  localparam addr_t A_P0   = 5'd2;
  localparam addr_t A_P1   = 5'd3;
  localparam addr_t A_P2   = 5'd4;
  localparam addr_t A_P3   = 5'd5;
  localparam addr_t A_Q    = 5'd6;
  localparam addr_t A_R    = 5'd7;
  localparam addr_t A_XP0  = 5'd8;
  localparam addr_t A_XP1  = 5'd9;
  localparam addr_t A_Y0   = 5'd10;
  localparam addr_t A_Y1   = 5'd11;
  localparam addr_t A_PP0  = 5'd12;
  localparam addr_t A_PP1  = 5'd13;
  localparam addr_t A_PP2  = 5'd14;
  localparam addr_t A_PP3  = 5'd15;
  localparam addr_t A_S0   = 5'd16;
  localparam addr_t A_S3   = 5'd17;
  localparam addr_t A_DET  = 5'd18;
  localparam addr_t A_T0   = 5'd19;
  localparam addr_t A_T1   = 5'd20;
  localparam addr_t A_K0   = 5'd21;
  localparam addr_t A_K1   = 5'd22;
  localparam addr_t A_K2   = 5'd23;
  localparam addr_t A_K3   = 5'd24;
  localparam addr_t A_N1   = 5'd25;
  localparam addr_t A_N2   = 5'd26;
  localparam addr_t A_ZERO = 5'd27;

  localparam pc_t PC_RELOAD = 7'd0;
  localparam pc_t PC_ITEM   = 7'd7;
  localparam pc_t PC_UPD    = 7'd46;
  localparam pc_t PC_FAULT  = 7'd72;

  typedef struct packed {
    op_e   op;
    src_e  src;
    addr_t rd;
    addr_t ra;
    addr_t rb;
    pc_t   tgt;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic in_load;
    logic cfg_we;
    logic we;
    logic mul_start;
    logic div_start;
    logic chk;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic nonpos;
    logic mul_done;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic uop_t f_op(op_e o, addr_t d, addr_t a, addr_t b);
    uop_t u;
    u.op = o; u.src = SRC_ZERO; u.rd = d; u.ra = a; u.rb = b; u.tgt = PC_RELOAD;
    return u;
  endfunction

  function automatic uop_t f_ld(addr_t d, src_e s);
    uop_t u;
    u = f_op(OP_LD, d, A_ZERO, A_ZERO);
    u.src = s;
    return u;
  endfunction

  function automatic uop_t f_ctl(op_e o, addr_t a, addr_t b, pc_t t);
    uop_t u;
    u = f_op(o, A_ZERO, a, b);
    u.tgt = t;
    return u;
  endfunction

  function automatic uop_t prog(pc_t pc);
    uop_t u;
    unique case (pc)
      7'd0:  u = f_ld(A_XD, SRC_INIT_D);
      7'd1:  u = f_ld(A_XA, SRC_INIT_A);
      7'd2:  u = f_ld(A_P0, SRC_COV);
      7'd3:  u = f_ld(A_P3, SRC_COV);
      7'd4:  u = f_ld(A_P1, SRC_ZERO);
      7'd5:  u = f_ld(A_P2, SRC_ZERO);
      7'd6:  u = f_ctl(OP_END, A_ZERO, A_ZERO, PC_RELOAD);
      7'd7:  u = f_ld(A_Q, SRC_Q);
      7'd8:  u = f_ld(A_R, SRC_R);
      7'd9:  u = f_ld(A_ZERO, SRC_ZERO);
      7'd10: u = f_ld(A_T0, SRC_CTRL_D);
      7'd11: u = f_op(OP_ADD, A_XP0, A_XD, A_T0);
      7'd12: u = f_ld(A_T0, SRC_CTRL_A);
      7'd13: u = f_op(OP_ADD, A_XP1, A_XA, A_T0);
      7'd14: u = f_ld(A_T0, SRC_MEAS_D);
      7'd15: u = f_op(OP_SUB, A_Y0, A_T0, A_XP0);
      7'd16: u = f_ld(A_T0, SRC_MEAS_A);
      7'd17: u = f_op(OP_SUB, A_Y1, A_T0, A_XP1);
      7'd18: u = f_op(OP_ADD, A_PP0, A_P0, A_Q);
      7'd19: u = f_op(OP_ADD, A_PP1, A_P1, A_ZERO);
      7'd20: u = f_op(OP_ADD, A_PP2, A_P2, A_ZERO);
      7'd21: u = f_op(OP_ADD, A_PP3, A_P3, A_Q);
      7'd22: u = f_op(OP_ADD, A_S0, A_PP0, A_R);
      7'd23: u = f_op(OP_ADD, A_S3, A_PP3, A_R);
      7'd24: u = f_op(OP_MUL, A_T0, A_S0, A_S3);
      7'd25: u = f_op(OP_MUL, A_T1, A_PP1, A_PP2);
      7'd26: u = f_op(OP_SUB, A_DET, A_T0, A_T1);
      7'd27: u = f_ctl(OP_CHK, A_DET, A_ZERO, PC_FAULT);
      7'd28: u = f_op(OP_SUB, A_N1, A_ZERO, A_PP1);
      7'd29: u = f_op(OP_SUB, A_N2, A_ZERO, A_PP2);
      7'd30: u = f_op(OP_MUL, A_T0, A_PP0, A_S3);
      7'd31: u = f_op(OP_MUL, A_T1, A_PP1, A_N2);
      7'd32: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd33: u = f_op(OP_DIV, A_K0, A_T0, A_DET);
      7'd34: u = f_op(OP_MUL, A_T0, A_PP0, A_N1);
      7'd35: u = f_op(OP_MUL, A_T1, A_PP1, A_S0);
      7'd36: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd37: u = f_op(OP_DIV, A_K1, A_T0, A_DET);
      7'd38: u = f_op(OP_MUL, A_T0, A_PP2, A_S3);
      7'd39: u = f_op(OP_MUL, A_T1, A_PP3, A_N2);
      7'd40: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd41: u = f_op(OP_DIV, A_K2, A_T0, A_DET);
      7'd42: u = f_op(OP_MUL, A_T0, A_PP2, A_N1);
      7'd43: u = f_op(OP_MUL, A_T1, A_PP3, A_S0);
      7'd44: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd45: u = f_op(OP_DIV, A_K3, A_T0, A_DET);
      7'd46: u = f_op(OP_MUL, A_T0, A_K0, A_Y0);
      7'd47: u = f_op(OP_MUL, A_T1, A_K1, A_Y1);
      7'd48: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd49: u = f_op(OP_ADD, A_XD, A_XP0, A_T0);
      7'd50: u = f_op(OP_MUL, A_T0, A_K2, A_Y0);
      7'd51: u = f_op(OP_MUL, A_T1, A_K3, A_Y1);
      7'd52: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd53: u = f_op(OP_ADD, A_XA, A_XP1, A_T0);
      7'd54: u = f_op(OP_MUL, A_T0, A_K0, A_PP0);
      7'd55: u = f_op(OP_MUL, A_T1, A_K1, A_PP2);
      7'd56: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd57: u = f_op(OP_SUB, A_P0, A_PP0, A_T0);
      7'd58: u = f_op(OP_MUL, A_T0, A_K0, A_PP1);
      7'd59: u = f_op(OP_MUL, A_T1, A_K1, A_PP3);
      7'd60: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd61: u = f_op(OP_SUB, A_P1, A_PP1, A_T0);
      7'd62: u = f_op(OP_MUL, A_T0, A_K2, A_PP0);
      7'd63: u = f_op(OP_MUL, A_T1, A_K3, A_PP2);
      7'd64: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd65: u = f_op(OP_SUB, A_P2, A_PP2, A_T0);
      7'd66: u = f_op(OP_MUL, A_T0, A_K2, A_PP1);
      7'd67: u = f_op(OP_MUL, A_T1, A_K3, A_PP3);
      7'd68: u = f_op(OP_ADD, A_T0, A_T0, A_T1);
      7'd69: u = f_op(OP_SUB, A_P3, A_PP3, A_T0);
      7'd70: u = f_ctl(OP_OUT, A_XD, A_XA, PC_RELOAD);
      7'd71: u = f_ctl(OP_END, A_ZERO, A_ZERO, PC_RELOAD);
      7'd72: u = f_ld(A_K0, SRC_ZERO);
      7'd73: u = f_ld(A_K1, SRC_ZERO);
      7'd74: u = f_ld(A_K2, SRC_ZERO);
      7'd75: u = f_ld(A_K3, SRC_ZERO);
      7'd76: u = f_ctl(OP_JMP, A_ZERO, A_ZERO, PC_UPD);
      default: u = f_ctl(OP_END, A_ZERO, A_ZERO, PC_RELOAD);
    endcase
    return u;
  endfunction

endpackage

// ----- src/kf2_stream_if.sv -----
interface kf2_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/kf2_mul.sv -----
module kf2_mul #(
  parameter int DW = kf2_pkg::DATA_WIDTH_DEF,
  parameter int FB = kf2_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] res_o
);
  localparam int CW    = 16;
  localparam int NC    = (DW + CW - 1) / CW;
  localparam int BW    = NC * CW;
  localparam int AW    = BW + DW;
  localparam int CNT_W = $clog2(NC + 1);
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};

  logic             busy_q, fin_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    ua_q, res_q;
  logic [BW-1:0]    ub_q;
  logic [AW-1:0]    acc_q, shifted;
  logic [DW-1:0]    ua, ub, lim;
  logic [DW+CW-1:0] pp;

  assign ua  = a_i[DW-1] ? DW'(~a_i + 1'b1) : a_i;
  assign ub  = b_i[DW-1] ? DW'(~b_i + 1'b1) : b_i;
  assign pp  = (DW+CW)'(ua_q) * (DW+CW)'(ub_q[BW-1 -: CW]);
  assign shifted = acc_q >> FB;
  assign lim = VMAX + DW'(neg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NC - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // top chunk of the multiplier first: shift the partial sum up each step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[DW-1] ^ b_i[DW-1];
      ua_q  <= ua;
      ub_q  <= BW'(ub);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << CW) + AW'(pp);
      ub_q  <= ub_q << CW;
    end
    if (fin_q) begin
      if (shifted > AW'(lim)) begin
        res_q <= neg_q ? ~VMAX : VMAX;
      end else if (neg_q) begin
        res_q <= DW'(~shifted[DW-1:0] + 1'b1);
      end else begin
        res_q <= shifted[DW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

// ----- src/kf2_div.sv -----
module kf2_div #(
  parameter int DW = kf2_pkg::DATA_WIDTH_DEF,
  parameter int FB = kf2_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [DW-1:0] res_o
);
  localparam int QW    = DW + FB;
  localparam int CNT_W = $clog2(QW + 1);
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};

  logic             busy_q, fin_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [QW-1:0]    n_q;
  logic [DW-1:0]    den_q, rem_q, res_q;
  logic [DW-1:0]    un, r2, lim;
  logic             ge;

  assign un  = num_i[DW-1] ? DW'(~num_i + 1'b1) : num_i;
  // remainder stays below the positive divisor, so its top bit is free
  assign r2  = {rem_q[DW-2:0], n_q[QW-1]};
  assign ge  = r2 >= den_q;
  assign lim = VMAX + DW'(neg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DW-1];
      n_q   <= {un, {FB{1'b0}}};
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? r2 - den_q : r2;
      n_q   <= {n_q[QW-2:0], ge};
    end
    if (fin_q) begin
      if (n_q > QW'(lim)) begin
        res_q <= neg_q ? ~VMAX : VMAX;
      end else if (neg_q) begin
        res_q <= DW'(~n_q[DW-1:0] + 1'b1);
      end else begin
        res_q <= n_q[DW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

// ----- src/kf2_ctrl.sv -----
module kf2_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cfg_valid_i,
  input  logic [kf2_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  output logic                           cfg_ready_o,
  input  kf2_pkg::sts_t                  sts_i,
  output kf2_pkg::cmd_t                  cmd_o
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  logic [1:0]     state_q, state_d;
  kf2_pkg::pc_t   pc_q, pc_d;
  kf2_pkg::uop_t  uop;
  logic           idle, unit_done;

  assign uop       = kf2_pkg::prog(pc_q);
  assign idle      = state_q == ST_IDLE;
  assign unit_done = (uop.op == kf2_pkg::OP_MUL) ? sts_i.mul_done : sts_i.div_done;

  // configuration wins when both channels present a transaction
  assign cfg_ready_o = idle;
  assign in_ready_o  = idle && !cfg_valid_i;

  always_comb begin
    state_d         = state_q;
    pc_d            = pc_q;
    cmd_o           = '0;
    cmd_o.uop       = uop;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          if (cfg_index_i <= kf2_pkg::CFG_LAST) begin
            cmd_o.cfg_we = 1'b1;
            pc_d         = kf2_pkg::PC_RELOAD;
            state_d      = ST_READ;
          end
        end else if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          pc_d          = kf2_pkg::PC_ITEM;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (uop.op) inside
          kf2_pkg::OP_LD, kf2_pkg::OP_ADD, kf2_pkg::OP_SUB: begin
            cmd_o.we = 1'b1;
            pc_d     = pc_q + 1'b1;
            state_d  = ST_READ;
          end
          kf2_pkg::OP_MUL: begin
            cmd_o.mul_start = 1'b1;
            state_d         = ST_WAIT;
          end
          kf2_pkg::OP_DIV: begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_WAIT;
          end
          kf2_pkg::OP_CHK: begin
            cmd_o.chk = 1'b1;
            pc_d      = sts_i.nonpos ? uop.tgt : pc_q + 1'b1;
            state_d   = ST_READ;
          end
          kf2_pkg::OP_JMP: begin
            pc_d    = uop.tgt;
            state_d = ST_READ;
          end
          kf2_pkg::OP_OUT: begin
            // hold until the output register can take the result
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              pc_d           = pc_q + 1'b1;
              state_d        = ST_READ;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_WAIT: begin
        if (unit_done) begin
          cmd_o.we = 1'b1;
          pc_d     = pc_q + 1'b1;
          state_d  = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // leave reset running the reload sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READ;
      pc_q    <= kf2_pkg::PC_RELOAD;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end
endmodule

// ----- src/kf2_dp.sv -----
module kf2_dp #(
  parameter int DW = kf2_pkg::DATA_WIDTH_DEF,
  parameter int FB = kf2_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kf2_pkg::cmd_t       cmd_i,
  output kf2_pkg::sts_t       sts_o,
  input  kf2_pkg::in_item_t   in_data_i,
  input  kf2_pkg::cfg_item_t  cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output kf2_pkg::out_item_t  out_data_o
);
  localparam int EW    = (DW > kf2_pkg::FIELD_W) ? DW : kf2_pkg::FIELD_W;
  localparam int LW    = EW + 1;
  localparam int DEPTH = 2 ** kf2_pkg::ADDR_W;
  localparam logic signed [DW-1:0] VMAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN  = ~VMAX;
  localparam logic signed [EW-1:0] O_MAX = EW'(2147483647);
  localparam logic signed [EW-1:0] O_MIN = ~O_MAX;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] ra_q, rb_q;

  kf2_pkg::in_item_t             in_q;
  logic [kf2_pkg::UNOISE_W-1:0]  cov_q, q_q, r_q;
  logic [kf2_pkg::FIELD_W-1:0]   init_d_q, init_a_q;
  logic                          fault_q, out_valid_q;
  kf2_pkg::out_item_t            out_q;

  logic signed [LW-1:0] ext;
  logic [DW:0]          sum, dif;
  logic [DW-1:0]        ld_val, wdata, mul_res, div_res;
  logic                 mul_done, div_done;

  function automatic logic [DW-1:0] sat_sum(logic [DW:0] s);
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? VMIN : VMAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic logic [kf2_pkg::FIELD_W-1:0] out32(logic [DW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'($signed(v));
    if (e > O_MAX) begin
      e = O_MAX;
    end else if (e < O_MIN) begin
      e = O_MIN;
    end
    return e[kf2_pkg::FIELD_W-1:0];
  endfunction

  always_comb begin
    case (cmd_i.uop.src)
      kf2_pkg::SRC_MEAS_D: ext = LW'(in_q.meas_distance);
      kf2_pkg::SRC_MEAS_A: ext = LW'(in_q.meas_angle);
      kf2_pkg::SRC_CTRL_D: ext = LW'(in_q.ctrl_distance);
      kf2_pkg::SRC_CTRL_A: ext = LW'(in_q.ctrl_angle);
      kf2_pkg::SRC_COV:    ext = LW'(cov_q);
      kf2_pkg::SRC_Q:      ext = LW'(q_q);
      kf2_pkg::SRC_R:      ext = LW'(r_q);
      kf2_pkg::SRC_INIT_D: ext = LW'($signed(init_d_q));
      kf2_pkg::SRC_INIT_A: ext = LW'($signed(init_a_q));
      default:             ext = '0;
    endcase
  end

  assign ld_val = (ext > LW'(VMAX)) ? VMAX :
                  (ext < LW'(VMIN)) ? VMIN : ext[DW-1:0];
  assign sum = {ra_q[DW-1], ra_q} + {rb_q[DW-1], rb_q};
  assign dif = {ra_q[DW-1], ra_q} - {rb_q[DW-1], rb_q};

  always_comb begin
    case (cmd_i.uop.op)
      kf2_pkg::OP_ADD: wdata = sat_sum(sum);
      kf2_pkg::OP_SUB: wdata = sat_sum(dif);
      kf2_pkg::OP_MUL: wdata = mul_res;
      kf2_pkg::OP_DIV: wdata = div_res;
      default:         wdata = ld_val;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.uop.rd] <= wdata;
    end
    ra_q <= mem[cmd_i.uop.ra];
    rb_q <= mem[cmd_i.uop.rb];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.out_load) begin
      out_q.filtered_distance <= out32(ra_q);
      out_q.filtered_angle    <= out32(rb_q);
      out_q.gain_fault        <= fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_q       <= kf2_pkg::RST_INIT_COV;
      q_q         <= kf2_pkg::RST_PROC_NOISE;
      r_q         <= kf2_pkg::RST_MEAS_NOISE;
      init_d_q    <= '0;
      init_a_q    <= '0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        unique case (cfg_data_i.index)
          kf2_pkg::CFG_INIT_COV:   cov_q    <= cfg_data_i.value[kf2_pkg::UNOISE_W-1:0];
          kf2_pkg::CFG_PROC_NOISE: q_q      <= cfg_data_i.value[kf2_pkg::UNOISE_W-1:0];
          kf2_pkg::CFG_MEAS_NOISE: r_q      <= cfg_data_i.value[kf2_pkg::UNOISE_W-1:0];
          kf2_pkg::CFG_INIT_DIST:  init_d_q <= cfg_data_i.value;
          kf2_pkg::CFG_INIT_ANGLE: init_a_q <= cfg_data_i.value;
          default: ;
        endcase
      end
      if (cmd_i.chk) begin
        fault_q <= sts_o.nonpos;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  kf2_mul #(.DW(DW), .FB(FB)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (ra_q),
    .b_i     (rb_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  kf2_div #(.DW(DW), .FB(FB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (ra_q),
    .den_i   (rb_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign sts_o.nonpos   = ra_q[DW-1] || (ra_q == '0);
  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// ----- src/kalman_filter_2d_identity.sv -----
// Two-state (distance, angle) Kalman filter with identity models, saturating signed
// fixed point with FRAC_BITS fraction bits in DATA_WIDTH-bit words. One measurement
// transaction gives one result transaction; items are processed one at a time by a
// microcoded sequencer over a 32-entry scratch memory, a shared multiplier working in
// 16-bit chunks of the multiplier and a shared bit-serial divider for the gain entries.
// When the innovation determinant is not positive the four gain divisions are
// skipped, the gain is zero and gain_fault is set. The result sits in an output
// register; the next item is taken once the current one has been handed over to it.
// Writing a known configuration index reloads estimates and covariance; the same
// reload runs after reset. Unknown indexes are accepted and dropped.
`include "assert_macros.svh"

module kalman_filter_2d_identity #(
  parameter int DATA_WIDTH = kf2_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = kf2_pkg::FRAC_BITS_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  kf2_stream_if.sink    in_i,
  kf2_stream_if.source  out_o,
  kf2_stream_if.sink    cfg_i
);
  kf2_pkg::cmd_t cmd;
  kf2_pkg::sts_t sts;
  logic          cfg_reload;

  assign cfg_reload = cfg_i.valid && cfg_i.ready && (cfg_i.data.index <= kf2_pkg::CFG_LAST);

  kf2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.data.index),
    .cfg_ready_o (cfg_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kf2_dp #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  `KF2_ASSERT(a_item_busy, (in_i.valid && in_i.ready) |=> !in_i.ready)
  `KF2_ASSERT(a_cfg_reload, cfg_reload |=> !in_i.ready)
  `KF2_ASSERT_NEVER(a_unit_overlap, sts.mul_done && sts.div_done)
  `KF2_ASSERT_NEVER(a_load_collide, cmd.in_load && cmd.cfg_we)
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import kf2_pkg::*;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kf2_stream_if #(.T(in_item_t))  in_if ();
  kf2_stream_if #(.T(out_item_t)) out_if ();
  kf2_stream_if #(.T(cfg_item_t)) cfg_if ();

  kalman_filter_2d_identity dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Fixed-point helpers at 32-bit data width, 16 fraction bits
  function automatic longint sat(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    logic [127:0] m;
    logic neg;
    p = 128'(signed'(a)) * 128'(signed'(b));
    neg = p[127];
    m = neg ? -p : p;
    m = m >> 16;
    if (neg) begin
      if (m > 128'(VMAX) + 1) return VMIN;
      return -longint'(m);
    end
    if (m > 128'(VMAX)) return VMAX;
    return longint'(m);
  endfunction

  function automatic longint qdiv(longint num, longint den);
    logic [127:0] n, q;
    logic neg;
    neg = num < 0;
    n = neg ? 128'(-num) : 128'(num);
    q = (n << 16) / 128'(den);
    if (neg) begin
      if (q > 128'(VMAX) + 1) return VMIN;
      return -longint'(q);
    end
    if (q > 128'(VMAX)) return VMAX;
    return longint'(q);
  endfunction

  class kf_scoreboard;
    longint cov_init, q_noise, r_noise, dist0, ang0;
    longint xd, xa;
    longint p[4];
    out_item_t pending[$];
    int errors;

    function new();
      cov_init = RST_INIT_COV;
      q_noise = RST_PROC_NOISE;
      r_noise = RST_MEAS_NOISE;
      dist0 = 0;
      ang0 = 0;
      errors = 0;
      reload();
    endfunction

    function void reload();
      xd = dist0;
      xa = ang0;
      p[0] = cov_init; p[1] = 0; p[2] = 0; p[3] = cov_init;
    endfunction

    function void write_reg(cfg_item_t c);
      case (c.index)
        CFG_INIT_COV:   cov_init = longint'(c.value[30:0]);
        CFG_PROC_NOISE: q_noise = longint'(c.value[30:0]);
        CFG_MEAS_NOISE: r_noise = longint'(c.value[30:0]);
        CFG_INIT_DIST:  dist0 = longint'(signed'(c.value));
        CFG_INIT_ANGLE: ang0 = longint'(signed'(c.value));
        default: return;
      endcase
      reload();
    endfunction

    function void note_input(in_item_t it);
      longint xp0, xp1, y0, y1, det;
      longint pp[4], s[4], adj[4], k[4];
      out_item_t r;
      xp0 = sat(xd + it.ctrl_distance);
      xp1 = sat(xa + it.ctrl_angle);
      y0 = sat(it.meas_distance - xp0);
      y1 = sat(it.meas_angle - xp1);
      pp[0] = sat(p[0] + q_noise); pp[1] = p[1]; pp[2] = p[2];
      pp[3] = sat(p[3] + q_noise);
      s[0] = sat(pp[0] + r_noise); s[1] = pp[1]; s[2] = pp[2];
      s[3] = sat(pp[3] + r_noise);
      det = sat(qmul(s[0], s[3]) - qmul(s[1], s[2]));
      k = '{0, 0, 0, 0};
      if (det > 0) begin
        adj[0] = s[3]; adj[1] = sat(-s[1]); adj[2] = sat(-s[2]); adj[3] = s[0];
        for (int i = 0; i < 2; i++)
          for (int j = 0; j < 2; j++)
            k[i*2+j] = qdiv(sat(qmul(pp[i*2], adj[j]) + qmul(pp[i*2+1], adj[2+j])), det);
      end
      xd = sat(xp0 + sat(qmul(k[0], y0) + qmul(k[1], y1)));
      xa = sat(xp1 + sat(qmul(k[2], y0) + qmul(k[3], y1)));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          p[i*2+j] = sat(pp[i*2+j] - sat(qmul(k[i*2], pp[j]) + qmul(k[i*2+1], pp[2+j])));
      r.filtered_distance = 32'(xd);
      r.filtered_angle = 32'(xa);
      r.gain_fault = det <= 0;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.filtered_distance !== want.filtered_distance)
        $display("%0t: filtered_distance expected %h actual %h", $time,
                 want.filtered_distance, got.filtered_distance);
      if (got.filtered_angle !== want.filtered_angle)
        $display("%0t: filtered_angle expected %h actual %h", $time,
                 want.filtered_angle, got.filtered_angle);
      if (got.gain_fault !== want.gain_fault)
        $display("%0t: gain_fault expected %b actual %b", $time,
                 want.gain_fault, got.gain_fault);
      if (got !== want) errors++;
    endfunction
  endclass

  kf_scoreboard sb = new();
  int stall_mode = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Receiver: stall pattern changes over the run
  always @(negedge clk_i) begin
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(3) != 0);
      default: out_if.ready <= ($urandom_range(9) == 0);
    endcase
    if ($urandom_range(299) == 0) stall_mode <= $urandom_range(2);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // called at a falling edge; drop valid at the falling edge after the transaction
  task automatic send_item(in_item_t it);
    in_if.data = it;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_item_t c;
    c.index = idx;
    c.value = val;
    cfg_if.data = c;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(c);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_field(int shape);
    case (shape)
      0: return $urandom;
      1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2000 << 8)) - (1000 << 8));
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int shape;
    shape = ($urandom_range(9) < 7) ? ($urandom_range(1) ? 1 : 3) : $urandom_range(2);
    it.meas_distance = rand_field(shape);
    it.meas_angle = rand_field(shape);
    it.ctrl_distance = ($urandom_range(3) == 0) ? rand_field(0) : rand_field(3) >>> 4;
    it.ctrl_angle = ($urandom_range(3) == 0) ? rand_field(0) : rand_field(3) >>> 4;
    return it;
  endfunction

  task automatic random_run(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(12, 1);
      if ($urandom_range(4) == 0) repeat ($urandom_range(40)) @(negedge clk_i);
      while (burst > 0 && n > 0) begin
        send_item(rand_item());
        burst--;
        n--;
      end
    end
  endtask

  task automatic set_config(logic [31:0] cov, logic [31:0] qn, logic [31:0] rn,
                            logic [31:0] d0, logic [31:0] a0);
    wait_idle();
    write_cfg(CFG_INIT_COV, cov);
    write_cfg(CFG_PROC_NOISE, qn);
    write_cfg(CFG_MEAS_NOISE, rn);
    write_cfg(CFG_INIT_DIST, d0);
    write_cfg(CFG_INIT_ANGLE, a0);
  endtask

  initial begin
    in_item_t it;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (20) @(negedge clk_i);

    // Directed: field extremes with reset configuration
    it = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000}; send_item(it);
    it = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff}; send_item(it);
    it = '{32'h0, 32'h0, 32'h0, 32'h0}; send_item(it);
    it = '{32'hffffffff, 32'h00010000, 32'h00000001, 32'hffff0000}; send_item(it);
    // Zero noise and covariance: determinant zero, gain fault
    set_config(32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000);
    it = '{32'h00050000, 32'hfffb0000, 32'h1, 32'hffffffff}; send_item(it);
    it = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000}; send_item(it);
    // Huge covariance: saturated products
    set_config(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    it = '{32'h12345678, 32'h87654321, 32'h0, 32'h0}; send_item(it);
    it = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff}; send_item(it);
    // Unknown indexes are dropped without reload
    wait_idle();
    write_cfg(3'd5, 32'hffffffff);
    write_cfg(3'd7, 32'h0);
    it = '{32'h00010000, 32'h00010000, 32'h0, 32'h0}; send_item(it);
    // Single write reloads state
    wait_idle();
    write_cfg(CFG_INIT_DIST, 32'h00030000);
    it = '{32'h00010000, 32'h00010000, 32'h0, 32'h0}; send_item(it);

    set_config(32'h00010000, 32'd655, 32'd6554, 32'h0, 32'h0);
    random_run(200);
    stall_mode = 1;
    wait_idle();
    random_run(150);
    set_config(32'h00100000, 32'h00001000, 32'h00020000, 32'hfff00000, 32'h00080000);
    random_run(150);
    set_config(32'h40000000, 32'h7fffffff, 32'h1, 32'h7fffffff, 32'h80000000);
    stall_mode = 2;
    random_run(60);
    set_config($urandom & 32'h7fffffff, $urandom_range(1 << 20), $urandom_range(1 << 20),
               $urandom, $urandom);
    stall_mode = 0;
    random_run(140);

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule
